// File: rtl/bda_pkg.sv
// Package for the button debounce and auto-repeat core.
// Holds the beat types, configuration register codes and reset values.
// No dependencies.
package bda_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RST = 16'd50;
    localparam logic [DELAY_W-1:0] HOLD_DELAY_RST     = 16'd500;
    localparam logic [DELAY_W-1:0] REPEAT_PERIOD_RST  = 16'd100;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } bda_in_t;

    typedef struct packed {
        logic press_event;
        logic stable_level;
    } bda_out_t;

    typedef struct packed {
        logic [DELAY_W-1:0] debounce_delay;
        logic [DELAY_W-1:0] hold_delay;
        logic [DELAY_W-1:0] repeat_period;
    } bda_cfg_t;

endpackage

// File: rtl/button_debounce_autorepeat_core.sv
// Button debounce with auto-repeat: top level with input and result registers.
// Path: a sample is captured in the input register, goes through the state update in bda_step
// and is loaded into the result register, from which its result beat is offered.
// Throughput: one sample per cycle while the receiver does not stall the result register.
// Reset (rst_n, asynchronous, active low): released and armed, delays 50/500/100 ms.
// Depends on bda_pkg, bda_cfg_regs and bda_step.
module button_debounce_autorepeat_core
    import bda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bda_in_t              in_beat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bda_out_t             out_beat,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data
);

    // The input register holds one accepted sample. It moves on to the state
    // update and the result register whenever the result register is empty or
    // its beat is being taken in the same cycle, so a new sample can enter in
    // every cycle while the output side keeps up.
    bda_in_t  in_item_reg;
    logic     in_valid_reg,  in_valid_next;
    bda_out_t out_beat_reg;
    logic     out_valid_reg, out_valid_next;

    logic     out_blocked;
    logic     advance;
    logic     in_take;
    bda_cfg_t cfg;
    bda_out_t result;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    bda_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register is blocked only while it holds a beat that the
    // receiver stalls. The held sample then waits, and so does the next one.
    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = in_valid_reg && !out_blocked;
    assign in_stall    = in_valid_reg && out_blocked;
    assign in_take     = in_valid && !in_stall;

    // The state update happens exactly once per sample, when it advances.
    bda_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_item (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (in_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_blocked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_beat;
        end
        if (advance)
        begin
            out_beat_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

// File: rtl/bda_cfg_regs.sv
// Configuration register file of the button debounce core.
// Depends on bda_pkg for register codes, reset values and bda_cfg_t.
module bda_cfg_regs
    import bda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data,
    output bda_cfg_t             cfg
);

    bda_cfg_t cfg_reg;
    bda_cfg_t cfg_next;

    // Writes to an unknown index are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_DELAY: cfg_next.debounce_delay = cfg_data;
                CFG_HOLD_DELAY:     cfg_next.hold_delay     = cfg_data;
                CFG_REPEAT_PERIOD:  cfg_next.repeat_period  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_delay <= DEBOUNCE_DELAY_RST;
            cfg_reg.hold_delay     <= HOLD_DELAY_RST;
            cfg_reg.repeat_period  <= REPEAT_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/bda_step.sv
// Debounce and auto-repeat state with its per-sample update logic.
// Depends on bda_pkg for the beat and configuration types.
module bda_step
    import bda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  bda_in_t  in_item,
    input  bda_cfg_t cfg,
    output bda_out_t result
);

    logic              last_raw_reg,    last_raw_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic              debounced_reg,   debounced_next;
    logic              armed_reg,       armed_next;
    logic [TIME_W-1:0] press_time_reg,  press_time_next;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              fire;

    always_comb
    begin
        last_raw_next    = in_item.raw_level;
        change_time_next = (in_item.raw_level != last_raw_reg) ? in_item.now_ms
                                                               : change_time_reg;
        since_change     = in_item.now_ms - change_time_next;
        since_press      = in_item.now_ms - press_time_reg;

        debounced_next = debounced_reg;
        if (since_change > TIME_W'(cfg.debounce_delay))
        begin
            debounced_next = in_item.raw_level;
        end

        armed_next      = armed_reg;
        press_time_next = press_time_reg;
        fire            = 1'b0;
        if (!debounced_next)
        begin
            if (armed_reg)
            begin
                armed_next      = 1'b0;
                press_time_next = in_item.now_ms;
                fire            = 1'b1;
            end
            else if (since_press > TIME_W'(cfg.hold_delay))
            begin
                press_time_next = press_time_reg + TIME_W'(cfg.repeat_period);
                fire            = 1'b1;
            end
        end
        else
        begin
            armed_next = 1'b1;
        end

        result.press_event  = fire;
        result.stable_level = debounced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b1;
            change_time_reg <= '0;
            debounced_reg   <= 1'b1;
            armed_reg       <= 1'b1;
            press_time_reg  <= '0;
        end
        else if (advance)
        begin
            last_raw_reg    <= last_raw_next;
            change_time_reg <= change_time_next;
            debounced_reg   <= debounced_next;
            armed_reg       <= armed_next;
            press_time_reg  <= press_time_next;
        end
    end

endmodule

// File: rtl/bda_checker.sv
// Port-level checker for button_debounce_autorepeat_core, attached by bind.
// Depends on bda_pkg for the beat types.
module bda_checker
    import bda_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input bda_out_t out_beat,
    input logic     out_valid,
    input logic     out_stall
);

    // A stalled result beat stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_beat))
        else $error("stalled result beat changed or vanished");

    // No result beat is shown while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // An event only fires while the debounced level is pressed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.press_event |-> !out_beat.stable_level)
        else $error("press event with released stable level");

    // The input side only stalls behind a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result register can move");

    // A result beat that newly appears follows a sample accepted through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result beat without an accepted sample");

endmodule

bind button_debounce_autorepeat_core bda_checker u_bda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_beat  (out_beat),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

// File: sim/bda_checker.sv
// Checker for the button debounce and auto-repeat core: watches all three channels.
// Predicts each result beat from the accepted samples and compares it on arrival.
// Depends on bda_pkg.
module bda_scoreboard
    import bda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  bda_in_t              in_beat,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  bda_out_t             out_beat,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    bda_cfg_t          cfg_model;
    logic              pin_prev;
    logic [TIME_W-1:0] edge_stamp;
    logic              level_q;
    logic              rearmed;
    logic [TIME_W-1:0] press_stamp;
    bda_out_t          expected_q[$];

    function automatic void log_miss(input string msg);
        if (fail_count < MAX_REPORTS)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fail_count++;
    endfunction

    // Advances the predicted debounce state by one sample and returns its result.
    function automatic bda_out_t predict_press(input bda_in_t s);
        bda_out_t          r;
        logic              fire;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] since_press;
        fire = 1'b0;
        if (s.raw_level != pin_prev)
        begin
            edge_stamp = s.now_ms;
        end
        since_edge = s.now_ms - edge_stamp;
        if (since_edge > TIME_W'(cfg_model.debounce_delay))
        begin
            level_q = s.raw_level;
        end
        pin_prev = s.raw_level;
        if (!level_q)
        begin
            since_press = s.now_ms - press_stamp;
            if (rearmed)
            begin
                rearmed = 1'b0;
                press_stamp = s.now_ms;
                fire = 1'b1;
            end
            else if (since_press > TIME_W'(cfg_model.hold_delay))
            begin
                press_stamp = press_stamp + TIME_W'(cfg_model.repeat_period);
                fire = 1'b1;
            end
        end
        else
        begin
            rearmed = 1'b1;
        end
        r.press_event = fire;
        r.stable_level = level_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bda_out_t want;
        if (!rst_n)
        begin
            cfg_model.debounce_delay = DEBOUNCE_DELAY_RST;
            cfg_model.hold_delay = HOLD_DELAY_RST;
            cfg_model.repeat_period = REPEAT_PERIOD_RST;
            pin_prev = 1'b1;
            edge_stamp = '0;
            level_q = 1'b1;
            rearmed = 1'b1;
            press_stamp = '0;
            expected_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_DELAY: cfg_model.debounce_delay = cfg_data;
                    CFG_HOLD_DELAY:     cfg_model.hold_delay = cfg_data;
                    CFG_REPEAT_PERIOD:  cfg_model.repeat_period = cfg_data;
                    default:            ;
                endcase
            end
            // Results are matched before new samples are queued, so a beat can
            // never be paired with a sample accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    log_miss($sformatf("result beat press=%0b level=%0b with nothing pending",
                        out_beat.press_event, out_beat.stable_level));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_beat.press_event !== want.press_event ||
                        out_beat.stable_level !== want.stable_level)
                    begin
                        log_miss($sformatf("expected press=%0b level=%0b, got press=%0b level=%0b",
                            want.press_event, want.stable_level,
                            out_beat.press_event, out_beat.stable_level));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(predict_press(in_beat));
            end
            pending_count = expected_q.size();
        end
    end

endmodule

// File: sim/tb_button_debounce_autorepeat_core.sv
// Testbench top for the button debounce and auto-repeat core.
// Drives samples and register writes, and gives the verdict from the checker's count.
// Depends on bda_pkg, button_debounce_autorepeat_core and bda_scoreboard.
module tb_button_debounce_autorepeat_core
    import bda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that maps to nothing; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the long receiver hold-off that fills the core up.
    localparam int HOLD_OFF_CYCLES = 200;
    // Random samples per phase, and the settle time after the last result.
    localparam int PHASE_ITEMS = 120;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    bda_in_t              in_beat;
    logic                 out_valid;
    logic                 out_stall;
    bda_out_t             out_beat;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DELAY_W-1:0]   cfg_data;
    int                   fail_count;
    int                   pending_count;

    // Stimulus-side state: the running millisecond clock, the register values
    // last written (used to scale the time steps), and the idling knobs.
    logic [TIME_W-1:0]    clock_ms;
    bda_cfg_t             cfg_shadow;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    int                   hold_off_asks;
    int                   hold_off_done;
    int                   items_sent;
    int                   quiet_cycles;

    button_debounce_autorepeat_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bda_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_beat       (in_beat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_beat      (out_beat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // The watchdog counts edges at which no beat moves on any channel. A long
    // stretch of silence means the core has hung, so the run ends there.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // Receiver side. out_stall is assigned only at falling edges, and not during a hold-off.
    // When the stimulus asks for a hold-off, the stall is held high for a long
    // stretch counted here, while the sender keeps offering samples, so the
    // core's registers fill and it has to stall its input.
    initial
    begin
        out_stall = 1'b0;
        hold_off_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_asks != hold_off_done)
            begin
                hold_off_done++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offers one sample taken dt ms after the previous one. Called at a falling
    // edge and returns at the falling edge after the beat was taken. Random idle
    // cycles come before the beat; once valid is up it stays up until accepted,
    // and the payload does not move while the core stalls.
    task automatic send_step(input logic lvl, input int unsigned dt);
        clock_ms = clock_ms + dt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= '{raw_level: lvl, now_ms: clock_ms};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Writes one register and leaves cfg_valid high, so that back-to-back
    // writes never drop and raise it within the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        case (idx)
            CFG_DEBOUNCE_DELAY: cfg_shadow.debounce_delay = val;
            CFG_HOLD_DELAY:     cfg_shadow.hold_delay = val;
            CFG_REPEAT_PERIOD:  cfg_shadow.repeat_period = val;
            default:            ;
        endcase
    endtask

    task automatic write_config(input logic [DELAY_W-1:0] deb, input logic [DELAY_W-1:0] hold,
                                input logic [DELAY_W-1:0] rep);
        write_reg(CFG_DEBOUNCE_DELAY, deb);
        write_reg(CFG_HOLD_DELAY, hold);
        write_reg(CFG_REPEAT_PERIOD, rep);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering samples and waits until every predicted result has come
    // back. Each sample produces exactly one result beat, so the core is idle
    // once nothing is pending.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // One realistic button press: contact bounce, a hold long enough to reach
    // the repeat phase most of the time, release bounce, and a released stretch.
    // Time steps scale with the current delays so every setting gets events.
    task automatic press_cycle();
        int unsigned span;
        span = cfg_shadow.debounce_delay + cfg_shadow.hold_delay + cfg_shadow.repeat_period;
        span = span / 4 + 2;
        repeat ($urandom_range(0, 4)) send_step(1'($urandom_range(0, 1)), $urandom_range(0, span / 4));
        repeat ($urandom_range(3, 16)) send_step(1'b0, $urandom_range(0, span));
        repeat ($urandom_range(0, 3)) send_step(1'($urandom_range(0, 1)), $urandom_range(0, span / 4));
        repeat ($urandom_range(2, 6)) send_step(1'b1, $urandom_range(0, span));
    endtask

    // A few junk samples: random levels, and timestamps that either creep
    // forward or jump anywhere in the 32-bit range, backwards included.
    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(1) == 1)
            begin
                clock_ms = $urandom();
                send_step(1'($urandom_range(0, 1)), 0);
            end
            else
            begin
                send_step(1'($urandom_range(0, 1)), $urandom_range(0, 3));
            end
        end
    endtask

    initial
    begin
        int phase_start;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEBOUNCE_DELAY;
        cfg_data = '0;
        cfg_shadow.debounce_delay = DEBOUNCE_DELAY_RST;
        cfg_shadow.hold_delay = HOLD_DELAY_RST;
        cfg_shadow.repeat_period = REPEAT_PERIOD_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_asks = 0;
        items_sent = 0;
        clock_ms = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset delays of 50/500/100 ms.
        send_step(1'b1, 0);
        send_step(1'b0, 10);          // level change restarts the debounce timer
        send_step(1'b0, 50);          // exactly at the debounce delay: not yet stable
        send_step(1'b0, 1);           // one ms past it: stable low, first press event
        send_step(1'b0, 500);         // exactly at the hold delay: no repeat
        send_step(1'b0, 1);           // past the hold delay: first repeat
        send_step(1'b0, 100);         // press time has moved by one period: repeat again
        send_step(1'b1, 38);          // release bounce
        send_step(1'b0, 1);
        send_step(1'b1, 1);
        send_step(1'b1, 51);          // stable high again, which re-arms
        clock_ms = 32'hFFFF_FFFF;     // timestamp jumps to the top of the range
        send_step(1'b1, 0);
        clock_ms = 32'hFFFF_FFF0;     // and goes backwards
        send_step(1'b0, 0);
        clock_ms = 32'h0000_0030;     // debounce interval straddles the wrap
        send_step(1'b0, 0);
        clock_ms = 32'h0000_0000;     // backwards again while held
        send_step(1'b0, 0);
        clock_ms = 32'hAAAA_5555;
        send_step(1'b1, 0);
        clock_ms = 32'h5555_AAAA;
        send_step(1'b0, 0);

        // All delays zero, repeat period zero included. A write to an unmapped
        // index goes first and must leave the registers untouched.
        drain();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        write_config(16'h0000, 16'h0000, 16'h0000);
        clock_ms = 32'd100;
        send_step(1'b1, 0);
        send_step(1'b1, 1);           // released and armed
        send_step(1'b0, 0);           // zero difference never passes the strict test
        send_step(1'b0, 1);           // stable low, press event
        send_step(1'b0, 0);           // no time since press: nothing
        send_step(1'b0, 1);           // repeat, press time stays put
        send_step(1'b0, 0);           // still past it, so another repeat

        // Random part, one register setting and one idling pattern per phase.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_config(DELAY_W'($urandom_range(0, 40)), DELAY_W'($urandom_range(0, 200)),
                                 DELAY_W'($urandom_range(1, 60)));
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                    write_config(16'h0000, 16'h0000, 16'h0000);
                end
                default:
                begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                    write_config(DELAY_W'($urandom_range(0, 65535)),
                                 DELAY_W'($urandom_range(0, 65535)),
                                 DELAY_W'($urandom_range(0, 65535)));
                    clock_ms = 32'hFFFF_FF00;
                end
            endcase
            // The long hold-off lands in the phases with a free-running sender.
            if (phase == 0 || phase == 2)
            begin
                hold_off_asks++;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 80)
                begin
                    press_cycle();
                end
                else
                begin
                    noise_burst();
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
